/* sv/assert_macros.svh */
// Assertion macros shared by the modules of the primality round checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/mrrc_pkg.sv */
// Types shared by the primality round checker modules.
package mrrc_pkg;

   // Round sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQR,
      ST_MUL,
      ST_FINISH
   } state_type;

endpackage

/* sv/mrrc_modmul.sv */
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
`include "assert_macros.svh"

module mrrc_modmul #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   input  logic [WIDTH-1:0] m,
   output logic             done,
   output logic [WIDTH-1:0] result
);

   localparam int CNTW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [WIDTH+1:0] sum;
   logic [WIDTH+1:0] m1;
   logic [WIDTH+1:0] m2;
   logic [WIDTH+1:0] sub1;
   logic [WIDTH+1:0] sub2;
   logic [WIDTH-1:0] r_step;

   // Double the partial remainder, add x for a set multiplier bit, reduce below m.
   // x and r are below m, so the sum stays below 3m and one pick of three suffices.
   always_comb begin
      m1   = {2'b00, m};
      m2   = {1'b0, m, 1'b0};
      sum  = {1'b0, r_ff, 1'b0} + (y_ff[WIDTH-1] ? {2'b00, x} : '0);
      sub1 = sum - m1;
      sub2 = sum - m2;
      if (sum >= m2) begin
         r_step = sub2[WIDTH-1:0];
      end else if (sum >= m1) begin
         r_step = sub1[WIDTH-1:0];
      end else begin
         r_step = sum[WIDTH-1:0];
      end
   end

   // Load on start, step while busy, pulse done after the last bit
   always_comb begin
      r_in    = r_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         r_in    = '0;
         y_in    = y;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = r_step;
         y_in   = {y_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + CNTW'(1);
         if (cnt_ff == CNTW'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      y_ff   <= y_in;
      cnt_ff <= cnt_in;
   end

   assign done   = done_ff;
   assign result = r_ff;

   `ASSERT_IMPLIES(a_done_reduced, clock, reset, done_ff, r_ff < m, "product not reduced below modulus")
   `ASSERT_IMPLIES(a_done_not_busy, clock, reset, done_ff, !busy_ff, "done raised while still busy")

endmodule

/* sv/miller_rabin_round_checker.sv */
// Miller-Rabin round checker. Each transfer on req_ carries a candidate, a witness base and a
// last-round flag; the block runs one round and folds a found witness into a sticky flag. On the
// last round it returns probably_prime on rsp_ and clears the flag; other rounds return nothing.
// Candidates of 2 pass, and even candidates or those of 1 or less fail, without the multiplier.
// Other candidates take one base reduction plus at most a squaring for each of the WIDTH bits of
// p-1 and a multiply for each set bit, all on one bit-serial modular multiplier. req_ready is
// low while a round is in progress; a finished verdict waits in an output register.
`include "assert_macros.svh"

module miller_rabin_round_checker #(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_candidate,
   input  logic [31:0] req_base,
   input  logic        req_last_round,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_probably_prime
);

   localparam int BITW = $clog2(WIDTH + 1);

   mrrc_pkg::state_type state_ff, state_in;

   logic [WIDTH-1:0] p_ff, p_in;
   logic [WIDTH-1:0] e_ff, e_in;
   logic [BITW-1:0]  bits_ff, bits_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [WIDTH-1:0] ared_ff, ared_in;
   logic             tail_ff, tail_in;
   logic             fail_ff, fail_in;
   logic             last_ff, last_in;
   logic             composite_ff, composite_in;
   logic             mm_start_ff, mm_start_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pp_ff, rsp_pp_in;

   logic [WIDTH-1:0] cand;
   logic [WIDTH-1:0] p_minus1;
   logic [WIDTH-1:0] mm_x;
   logic [WIDTH-1:0] mm_y;
   logic [WIDTH-1:0] mm_result;
   logic             mm_done;
   logic             req_xfer;

   assign cand     = req_candidate[WIDTH-1:0];
   assign p_minus1 = p_ff - WIDTH'(1);
   assign req_xfer = req_valid && req_ready;

   // Select multiplier operands: reduce the base as 1*base, square acc, or multiply acc by the reduced base
   always_comb begin
      unique case (state_ff)
         mrrc_pkg::ST_REDUCE: begin
            mm_x = WIDTH'(1);
            mm_y = base_ff;
         end
         mrrc_pkg::ST_MUL: begin
            mm_x = acc_ff;
            mm_y = ared_ff;
         end
         default: begin
            mm_x = acc_ff;
            mm_y = acc_ff;
         end
      endcase
   end

   mrrc_modmul #(
      .WIDTH(WIDTH)
   ) u_modmul (
      .clock (clock),
      .reset (reset),
      .start (mm_start_ff),
      .x     (mm_x),
      .y     (mm_y),
      .m     (p_ff),
      .done  (mm_done),
      .result(mm_result)
   );

   // Sequence one round: screen trivial candidates, reduce base, left-to-right powering
   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      e_in         = e_ff;
      bits_in      = bits_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      ared_in      = ared_ff;
      tail_in      = tail_ff;
      fail_in      = fail_ff;
      last_in      = last_ff;
      composite_in = composite_ff;
      mm_start_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pp_in    = rsp_pp_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         mrrc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               p_in    = cand;
               e_in    = cand - WIDTH'(1);
               bits_in = BITW'(WIDTH);
               acc_in  = WIDTH'(1);
               base_in = req_base[WIDTH-1:0];
               tail_in = 1'b0;
               last_in = req_last_round;
               if (cand == WIDTH'(2)) begin
                  fail_in  = 1'b0;
                  state_in = mrrc_pkg::ST_FINISH;
               end else if (cand[WIDTH-1:1] == '0 || !cand[0]) begin
                  fail_in  = 1'b1;
                  state_in = mrrc_pkg::ST_FINISH;
               end else begin
                  mm_start_in = 1'b1;
                  state_in    = mrrc_pkg::ST_REDUCE;
               end
            end
         end

         mrrc_pkg::ST_REDUCE: begin
            if (mm_done) begin
               ared_in     = mm_result;
               mm_start_in = 1'b1;
               state_in    = mrrc_pkg::ST_SQR;
            end
         end

         mrrc_pkg::ST_SQR: begin
            if (mm_done) begin
               acc_in = mm_result;
               if (e_ff[WIDTH-1]) begin
                  mm_start_in = 1'b1;
                  state_in    = mrrc_pkg::ST_MUL;
               end else if (tail_ff && bits_ff == BITW'(1)) begin
                  // final squaring never reached p-1: witness found
                  fail_in  = 1'b1;
                  state_in = mrrc_pkg::ST_FINISH;
               end else if (tail_ff && mm_result == p_minus1) begin
                  fail_in  = 1'b0;
                  state_in = mrrc_pkg::ST_FINISH;
               end else begin
                  e_in        = {e_ff[WIDTH-2:0], 1'b0};
                  bits_in     = bits_ff - BITW'(1);
                  mm_start_in = 1'b1;
               end
            end
         end

         mrrc_pkg::ST_MUL: begin
            if (mm_done) begin
               acc_in = mm_result;
               if (e_ff[WIDTH-2:0] == '0 &&
                   (mm_result == WIDTH'(1) || mm_result == p_minus1)) begin
                  // a^d is 1 or p-1: round passes
                  fail_in  = 1'b0;
                  state_in = mrrc_pkg::ST_FINISH;
               end else begin
                  // after the lowest set bit only the squaring tail remains
                  if (e_ff[WIDTH-2:0] == '0) begin
                     tail_in = 1'b1;
                  end
                  e_in        = {e_ff[WIDTH-2:0], 1'b0};
                  bits_in     = bits_ff - BITW'(1);
                  mm_start_in = 1'b1;
                  state_in    = mrrc_pkg::ST_SQR;
               end
            end
         end

         mrrc_pkg::ST_FINISH: begin
            if (!last_ff) begin
               composite_in = composite_ff || fail_ff;
               state_in     = mrrc_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pp_in    = !(composite_ff || fail_ff);
               composite_in = 1'b0;
               state_in     = mrrc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mrrc_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrrc_pkg::ST_IDLE;
         composite_ff <= 1'b0;
         mm_start_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         composite_ff <= composite_in;
         mm_start_ff  <= mm_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold round payload
   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      e_ff      <= e_in;
      bits_ff   <= bits_in;
      acc_ff    <= acc_in;
      base_ff   <= base_in;
      ared_ff   <= ared_in;
      tail_ff   <= tail_in;
      fail_ff   <= fail_in;
      last_ff   <= last_in;
      rsp_pp_ff <= rsp_pp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_probably_prime = rsp_pp_ff;

   `ASSERT_IMPLIES(a_done_in_round, clock, reset, mm_done, state_ff == mrrc_pkg::ST_REDUCE || state_ff == mrrc_pkg::ST_SQR || state_ff == mrrc_pkg::ST_MUL, "multiplier result outside a round")
   `ASSERT_IMPLIES(a_rsp_from_last, clock, reset, $rose(rsp_valid_ff), $past(state_ff == mrrc_pkg::ST_FINISH) && $past(last_ff), "verdict raised without a last round")
   `ASSERT_NEXT(a_accept_starts, clock, reset, req_xfer, state_ff == mrrc_pkg::ST_FINISH || mm_start_ff, "accepted round neither finished nor started")

endmodule

/* tb/sv/miller_rabin_round_checker_check.sv */
// Transfer monitor, round predictor and verdict scoreboard for the Miller-Rabin round checker.
module miller_rabin_round_checker_check #(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_candidate,
   input  logic [31:0] req_base,
   input  logic        req_last_round,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_probably_prime,
   output int          mismatches,
   output int          verdicts_awaited
);

   localparam logic [63:0] VALUE_MASK = (64'd1 << WIDTH) - 64'd1;

   // Verdicts still to come back, oldest first, and the sticky witness flag
   bit verdicts_due [$];
   bit witness_seen;

   // Operands stay below 2^32, so a 64-bit product never overflows
   function automatic logic [63:0] mod_mul(input logic [63:0] x, input logic [63:0] y,
                                           input logic [63:0] m);
      return (x * y) % m;
   endfunction

   function automatic logic [63:0] mod_pow(input logic [63:0] b, input logic [63:0] e,
                                           input logic [63:0] m);
      logic [63:0] acc;
      acc = 64'd1 % m;
      b = b % m;
      while (e != 64'd0) begin
         if (e[0]) acc = mod_mul(acc, b, m);
         b = mod_mul(b, b, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   // Return 1 when this round shows the candidate is not prime
   function automatic bit round_finds_witness(input logic [63:0] p, input logic [63:0] a);
      logic [63:0] d;
      logic [63:0] x;
      int          twos;
      if (p == 64'd2) return 1'b0;
      if (p <= 64'd1 || !p[0]) return 1'b1;
      d = p - 64'd1;
      twos = 0;
      while (!d[0]) begin
         d = d >> 1;
         twos++;
      end
      x = mod_pow(a, d, p);
      if (x == 64'd1) return 1'b0;
      for (int i = 0; i < twos; i++) begin
         if (x == p - 64'd1) return 1'b0;
         x = mod_mul(x, x, p);
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      bit verdict;
      if (reset) begin
         verdicts_due.delete();
         witness_seen = 1'b0;
         mismatches <= 0;
         verdicts_awaited <= 0;
      end else begin
         // Compare a response transfer with the oldest verdict due
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: probably_prime expected none, actual %0b", $time,
                        rsp_probably_prime);
               mismatches <= mismatches + 1;
            end else begin
               verdict = verdicts_due.pop_front();
               if (rsp_probably_prime !== verdict) begin
                  $display("%0t: probably_prime expected %0b, actual %0b", $time, verdict,
                           rsp_probably_prime);
                  mismatches <= mismatches + 1;
               end
            end
         end
         // Fold each accepted round into the flag; queue a verdict on the last one
         if (req_valid && req_ready) begin
            if (round_finds_witness(req_candidate & VALUE_MASK, req_base & VALUE_MASK))
               witness_seen = 1'b1;
            if (req_last_round) begin
               verdicts_due.push_back(!witness_seen);
               witness_seen = 1'b0;
            end
         end
         verdicts_awaited <= verdicts_due.size();
      end
   end

endmodule

/* tb/sv/miller_rabin_round_checker_tb.sv */
// Stimulus and verdict for the Miller-Rabin round checker, with the checker alongside.
module miller_rabin_round_checker_tb;

   localparam int WIDTH      = 32;
   localparam int ROUND_MAX  = (2 * WIDTH + 1) * (WIDTH + 2) + 3;
   localparam int ITEM_COUNT = 140;
   localparam int CALM_FROM  = 110;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_candidate;
   logic [31:0] req_base;
   logic        req_last_round;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_probably_prime;

   int mismatches;
   int verdicts_awaited;
   int rounds_sent;
   int ready_stall;
   bit calm;

   always #1 clock = ~clock;

   miller_rabin_round_checker #(
      .WIDTH(WIDTH)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_candidate     (req_candidate),
      .req_base          (req_base),
      .req_last_round    (req_last_round),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_probably_prime(rsp_probably_prime)
   );

   miller_rabin_round_checker_check #(
      .WIDTH(WIDTH)
   ) i_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_candidate     (req_candidate),
      .req_base          (req_base),
      .req_last_round    (req_last_round),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_probably_prime(rsp_probably_prime),
      .mismatches        (mismatches),
      .verdicts_awaited  (verdicts_awaited)
   );

   // Stall the response side in random bursts until the calm stretch
   always @(negedge clock) begin
      if (ready_stall == 0 && !calm && $urandom_range(0, 3) == 0)
         ready_stall = $urandom_range(1, 11);
      if (ready_stall > 0) begin
         rsp_ready <= 1'b0;
         ready_stall--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offer one round, after an optional idle burst, and hold it until the transfer
   task automatic send_round(input logic [31:0] cand, input logic [31:0] base,
                             input logic last);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_candidate  <= cand;
      req_base       <= base;
      req_last_round <= last;
      do @(posedge clock); while (!req_ready);
      rounds_sent++;
      if (rounds_sent >= CALM_FROM) calm = 1'b1;
      @(negedge clock);
   endtask

   initial begin
      int          rounds;
      int          kind;
      logic [31:0] cand;
      logic [31:0] base;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_candidate  = '0;
      req_base       = '0;
      req_last_round = 1'b0;
      rsp_ready      = 1'b0;
      rounds_sent    = 0;
      ready_stall    = 0;
      calm           = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: trivial candidates, field extremes, odd bases, pseudoprimes
      send_round(32'd0, 32'd2, 1'b1);
      send_round(32'd1, 32'd2, 1'b1);
      send_round(32'd2, 32'd0, 1'b1);
      send_round(32'd4, 32'd3, 1'b1);
      send_round(32'hFFFF_FFFE, 32'd5, 1'b1);
      send_round(32'd3, 32'd2, 1'b1);
      send_round(32'hFFFF_FFFB, 32'd2, 1'b1);
      send_round(32'hFFFF_FFFB, 32'hFFFF_FFFA, 1'b1);
      send_round(32'hFFFF_FFFF, 32'd3, 1'b1);
      send_round(32'd13, 32'd1, 1'b1);
      send_round(32'd13, 32'd0, 1'b1);
      send_round(32'd13, 32'd26, 1'b1);
      send_round(32'd13, 32'd27, 1'b1);
      send_round(32'd97, 32'hFFFF_FFFF, 1'b1);
      send_round(32'd2047, 32'd2, 1'b1);
      send_round(32'd3215031751, 32'd2, 1'b1);
      send_round(32'd561, 32'd2, 1'b1);
      // Several rounds per test, and a candidate that changes mid-test
      send_round(32'd65537, 32'd3, 1'b0);
      send_round(32'd65537, 32'd5, 1'b0);
      send_round(32'd65537, 32'd7, 1'b1);
      send_round(32'd561, 32'd2, 1'b0);
      send_round(32'd65537, 32'd3, 1'b1);
      send_round(32'd2047, 32'd2, 1'b0);
      send_round(32'd2047, 32'd3, 1'b1);

      // Random tests of one to four rounds, mostly on one candidate each
      while (rounds_sent < ITEM_COUNT) begin
         rounds = $urandom_range(1, 4);
         kind   = $urandom_range(0, 9);
         cand   = $urandom | 32'd1;
         for (int r = 0; r < rounds; r++) begin
            case (kind)
               4, 5: begin
                  case ($urandom_range(0, 7))
                     0: cand = 32'hFFFF_FFFB;
                     1: cand = 32'd2147483647;
                     2: cand = 32'd65537;
                     3: cand = 32'd1000000007;
                     4: cand = 32'd7919;
                     5: cand = 32'd5;
                     6: cand = 32'd4294967279;
                     default: cand = 32'd97;
                  endcase
               end
               6: if (r == 0) cand = $urandom_range(0, 64);
               7: if (r == 0) cand = $urandom;
               8: begin
                  case ($urandom_range(0, 4))
                     0: cand = 32'd2047;
                     1: cand = 32'd3215031751;
                     2: cand = 32'd561;
                     3: cand = 32'd1373653;
                     default: cand = 32'd25326001;
                  endcase
               end
               9: cand = $urandom;
               default: ;
            endcase
            if (cand > 32'd3 && $urandom_range(0, 4) != 0)
               base = $urandom_range(2, cand - 32'd1);
            else
               base = $urandom;
            send_round(cand, base, r == rounds - 1);
         end
      end
      req_valid <= 1'b0;

      // Drain the verdicts still due, then let any late response show itself
      while (verdicts_awaited != 0) @(posedge clock);
      repeat (ROUND_MAX + 100) @(posedge clock);
      if (mismatches == 0 && verdicts_awaited == 0) begin
         $display("miller_rabin_round_checker_tb: PASS");
      end else begin
         $display("miller_rabin_round_checker_tb: FAIL");
      end
      $finish;
   end

   // Give up long after the slowest correct run would have finished
   initial begin
      #3000000;
      $display("miller_rabin_round_checker_tb: FAIL");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/mrrc_pkg.sv
sv/mrrc_modmul.sv
sv/miller_rabin_round_checker.sv
tb/sv/miller_rabin_round_checker_check.sv
tb/sv/miller_rabin_round_checker_tb.sv
